[hdl/crc16fr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crc16fr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_EOF     = 3'd7
    } t_phase;

    typedef logic [2:0] t_status;

    localparam t_status ST_NONE     = 3'd0;
    localparam t_status ST_OK       = 3'd1;
    localparam t_status ST_OVERSIZE = 3'd2;
    localparam t_status ST_CRC_BAD  = 3'd3;
    localparam t_status ST_EOF_BAD  = 3'd4;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_START_MARKER = 2'd0;
    localparam t_cfg_index CFG_END_MARKER   = 2'd1;
    localparam t_cfg_index CFG_MAX_LENGTH   = 2'd2;

    localparam logic [7:0]  START_MARKER_RST = 8'hAA;
    localparam logic [7:0]  END_MARKER_RST   = 8'h55;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'd256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

endpackage

`default_nettype wire

[hdl/crc16fr_crc_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module crc16fr_crc_step (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ crc16fr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

[hdl/crc16_framed_message_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// rx        in         i_rx_valid / o_rx_ready   i_rx_byte
// result    out        o_res_valid / i_res_ready payload and frame status fields
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One received byte is taken per cycle; its result is written to the output register on the
// clock edge that takes the request. The frame state and the CRC update on that same edge.
// The input is stalled only while the output register is full and not being taken.
// Reset returns to hunting for a start marker and restores the register defaults.

module crc16_framed_message_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,

    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_index,
    output logic [2:0]       o_frame_status,
    output logic [7:0]       o_frame_command,
    output logic [15:0]      o_frame_length,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [7:0]  r_start_marker;
    logic [7:0]  r_end_marker;
    logic [15:0] r_max_length;

    crc16fr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;

    logic        r_res_valid;
    logic        r_pv, n_pv;
    logic [7:0]  r_pb, n_pb;
    logic [15:0] r_pi, n_pi;
    crc16fr_pkg::t_status r_st, n_st;
    logic [7:0]  r_fc, n_fc;
    logic [15:0] r_fl, n_fl;

    logic        accept;
    logic [15:0] crc_base;
    logic [15:0] crc_fed;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_res_valid || i_res_ready;
    assign accept      = i_rx_valid && o_rx_ready;

    assign crc_base  = (r_phase == crc16fr_pkg::PH_HUNT) ? crc16fr_pkg::CRC_INIT : r_crc;
    assign len_full  = {i_rx_byte, r_len[7:0]};
    assign count_inc = r_count + 16'd1;

    crc16fr_crc_step u_crc_step (
        .i_crc  (crc_base),
        .i_byte (i_rx_byte),
        .o_crc  (crc_fed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= crc16fr_pkg::START_MARKER_RST;
            r_end_marker   <= crc16fr_pkg::END_MARKER_RST;
            r_max_length   <= crc16fr_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crc16fr_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data[7:0];
                crc16fr_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_data[7:0];
                crc16fr_pkg::CFG_MAX_LENGTH:   r_max_length   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Next state of the frame tracker.
    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_count  = r_count;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        case (r_phase)
            crc16fr_pkg::PH_HUNT: begin
                if (i_rx_byte == r_start_marker) begin
                    n_crc   = crc_fed;
                    n_count = 16'd0;
                    n_phase = crc16fr_pkg::PH_CMD;
                end
            end
            crc16fr_pkg::PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_crc   = crc_fed;
                n_phase = crc16fr_pkg::PH_LEN_LO;
            end
            crc16fr_pkg::PH_LEN_LO: begin
                n_len   = {8'h00, i_rx_byte};
                n_crc   = crc_fed;
                n_phase = crc16fr_pkg::PH_LEN_HI;
            end
            crc16fr_pkg::PH_LEN_HI: begin
                n_len   = len_full;
                n_crc   = crc_fed;
                n_count = 16'd0;
                if (len_full > r_max_length) begin
                    n_phase = crc16fr_pkg::PH_HUNT;
                end else if (len_full == 16'd0) begin
                    n_phase = crc16fr_pkg::PH_CRC_LO;
                end else begin
                    n_phase = crc16fr_pkg::PH_PAYLOAD;
                end
            end
            crc16fr_pkg::PH_PAYLOAD: begin
                n_crc   = crc_fed;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = crc16fr_pkg::PH_CRC_LO;
                end
            end
            crc16fr_pkg::PH_CRC_LO: begin
                n_rx_crc = {8'h00, i_rx_byte};
                n_phase  = crc16fr_pkg::PH_CRC_HI;
            end
            crc16fr_pkg::PH_CRC_HI: begin
                n_rx_crc = {i_rx_byte, r_rx_crc[7:0]};
                n_phase  = crc16fr_pkg::PH_EOF;
            end
            default: begin
                n_phase = crc16fr_pkg::PH_HUNT;
            end
        endcase
    end

    // Result fields for the byte being taken.
    always_comb begin
        n_pv = 1'b0;
        n_pb = 8'h00;
        n_pi = 16'd0;
        n_st = crc16fr_pkg::ST_NONE;
        n_fc = 8'h00;
        n_fl = 16'd0;
        case (r_phase)
            crc16fr_pkg::PH_LEN_HI: begin
                if (len_full > r_max_length) begin
                    n_st = crc16fr_pkg::ST_OVERSIZE;
                    n_fc = r_cmd;
                    n_fl = len_full;
                end
            end
            crc16fr_pkg::PH_PAYLOAD: begin
                n_pv = 1'b1;
                n_pb = i_rx_byte;
                n_pi = r_count;
            end
            crc16fr_pkg::PH_EOF: begin
                if (i_rx_byte != r_end_marker) begin
                    n_st = crc16fr_pkg::ST_EOF_BAD;
                end else if (r_crc != r_rx_crc) begin
                    n_st = crc16fr_pkg::ST_CRC_BAD;
                end else begin
                    n_st = crc16fr_pkg::ST_OK;
                end
                n_fc = r_cmd;
                n_fl = r_len;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= crc16fr_pkg::PH_HUNT;
            r_cmd       <= 8'h00;
            r_len       <= 16'd0;
            r_count     <= 16'd0;
            r_crc       <= crc16fr_pkg::CRC_INIT;
            r_rx_crc    <= 16'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_cmd    <= n_cmd;
                r_len    <= n_len;
                r_count  <= n_count;
                r_crc    <= n_crc;
                r_rx_crc <= n_rx_crc;
            end
            if (accept) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pv <= n_pv;
            r_pb <= n_pb;
            r_pi <= n_pi;
            r_st <= n_st;
            r_fc <= n_fc;
            r_fl <= n_fl;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_payload_valid = r_pv;
    assign o_payload_byte  = r_pb;
    assign o_payload_index = r_pi;
    assign o_frame_status  = r_st;
    assign o_frame_command = r_fc;
    assign o_frame_length  = r_fl;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import crc16fr_pkg::*;

    localparam t_cfg_index CFG_SPARE   = 2'd3;
    localparam int         STALL_LIMIT = 5000;

    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic [15:0] pay_index;
        t_status     status;
        logic [7:0]  command;
        logic [15:0] frame_len;
    } frame_out_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_res_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    t_cfg_index  i_cfg_index = CFG_START_MARKER;
    logic [15:0] i_cfg_data  = 16'h0000;
    logic        o_rx_ready;
    logic        o_res_valid;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_index;
    logic [2:0]  o_frame_status;
    logic [7:0]  o_frame_command;
    logic [15:0] o_frame_length;
    logic        o_cfg_ready;

    crc16_framed_message_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_status  (o_frame_status),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Register copies and deframer state mirrored by the predictor.
    logic [7:0]  sof_byte  = START_MARKER_RST;
    logic [7:0]  eof_byte  = END_MARKER_RST;
    logic [15:0] len_limit = MAX_LENGTH_RST;

    t_phase      frame_step   = PH_HUNT;
    logic [7:0]  held_cmd     = 8'h00;
    logic [15:0] held_len     = 16'h0000;
    logic [15:0] payload_seen = 16'h0000;
    logic [15:0] crc_acc      = CRC_INIT;
    logic [15:0] crc_got      = 16'h0000;

    logic [7:0]  link_bytes[$];
    frame_out_t  deframed_q[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int queued_items      = 0;
    int bytes_taken       = 0;
    int payload_bytes     = 0;
    int settings_used     = 1;
    int mismatches        = 0;
    int stall_cycles      = 0;
    int status_seen[8];

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic frame_out_t deframe_byte(input logic [7:0] b);
        frame_out_t r;
        r = '0;
        r.status = ST_NONE;
        case (frame_step)
            PH_HUNT: begin
                if (b == sof_byte) begin
                    crc_acc = crc16_update(CRC_INIT, b);
                    payload_seen = 16'h0000;
                    frame_step = PH_CMD;
                end
            end
            PH_CMD: begin
                held_cmd = b;
                crc_acc = crc16_update(crc_acc, b);
                frame_step = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                held_len = {8'h00, b};
                crc_acc = crc16_update(crc_acc, b);
                frame_step = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held_len = {b, held_len[7:0]};
                crc_acc = crc16_update(crc_acc, b);
                payload_seen = 16'h0000;
                if (held_len > len_limit) begin
                    r.status = ST_OVERSIZE;
                    r.command = held_cmd;
                    r.frame_len = held_len;
                    frame_step = PH_HUNT;
                end else if (held_len == 16'h0000) begin
                    frame_step = PH_CRC_LO;
                end else begin
                    frame_step = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                r.pay_valid = 1'b1;
                r.pay_byte = b;
                r.pay_index = payload_seen;
                crc_acc = crc16_update(crc_acc, b);
                payload_seen = payload_seen + 16'd1;
                if (payload_seen >= held_len) begin
                    frame_step = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                crc_got = {8'h00, b};
                frame_step = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                crc_got = {b, crc_got[7:0]};
                frame_step = PH_EOF;
            end
            default: begin
                if (b != eof_byte) begin
                    r.status = ST_EOF_BAD;
                end else if (crc_acc != crc_got) begin
                    r.status = ST_CRC_BAD;
                end else begin
                    r.status = ST_OK;
                end
                r.command = held_cmd;
                r.frame_len = held_len;
                frame_step = PH_HUNT;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input frame_out_t want,
                                   input frame_out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected pv=%0d byte=%02h idx=%0d st=%0d cmd=%02h len=%0d",
                     $realtime, what, want.pay_valid, want.pay_byte, want.pay_index,
                     want.status, want.command, want.frame_len);
            $display("%0t %s:      got pv=%0d byte=%02h idx=%0d st=%0d cmd=%02h len=%0d",
                     $realtime, what, got.pay_valid, got.pay_byte, got.pay_index,
                     got.status, got.command, got.frame_len);
        end
    endtask

    // Request driver for the receive channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || o_rx_ready) begin
            if (link_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= link_bytes.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        frame_out_t got;
        frame_out_t want;
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) begin
                bytes_taken++;
                deframed_q.push_back(deframe_byte(i_rx_byte));
            end
            if (o_res_valid && i_res_ready) begin
                got.pay_valid = o_payload_valid;
                got.pay_byte  = o_payload_byte;
                got.pay_index = o_payload_index;
                got.status    = o_frame_status;
                got.command   = o_frame_command;
                got.frame_len = o_frame_length;
                if (deframed_q.size() == 0) begin
                    report_mismatch("result with nothing predicted", '0, got);
                end else begin
                    want = deframed_q.pop_front();
                    if (got !== want) begin
                        report_mismatch("result mismatch", want, got);
                    end else begin
                        status_seen[want.status]++;
                        if (want.pay_valid) begin
                            payload_bytes++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d results still predicted.", deframed_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_START_MARKER: sof_byte = val[7:0];
            CFG_END_MARKER:   eof_byte = val[7:0];
            CFG_MAX_LENGTH:   len_limit = val;
            default: ;
        endcase
    endtask

    task automatic program_setting(input logic [7:0] sof, input logic [7:0] eof,
                                   input logic [15:0] limit);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_START_MARKER, {junk, sof});
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_END_MARKER, {junk, eof});
        write_reg(CFG_MAX_LENGTH, limit);
        settings_used++;
    endtask

    task automatic push_link_byte(input logic [7:0] b, input bit counted);
        link_bytes.push_back(b);
        if (counted) begin
            queued_items++;
        end
    endtask

    task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] len,
                               input logic [15:0] crc_flip, input logic [7:0] closing);
        logic [15:0] crc;
        logic [7:0]  b;
        push_link_byte(sof_byte, 1'b1);
        push_link_byte(cmd, 1'b1);
        push_link_byte(len[7:0], 1'b1);
        push_link_byte(len[15:8], 1'b1);
        crc = crc16_update(crc16_update(crc16_update(crc16_update(CRC_INIT, sof_byte),
                                                     cmd), len[7:0]), len[15:8]);
        if (len <= len_limit) begin
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                crc = crc16_update(crc, b);
                push_link_byte(b, 1'b1);
            end
            crc = crc ^ crc_flip;
            push_link_byte(crc[7:0], 1'b1);
            push_link_byte(crc[15:8], 1'b1);
            push_link_byte(closing, 1'b1);
        end
    endtask

    task automatic queue_random_frame();
        int          kind;
        int          pick;
        int          span;
        logic [7:0]  cmd;
        logic [7:0]  b;
        logic [15:0] len;
        logic [15:0] flip;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        cmd  = 8'($urandom_range(0, 255));
        span = (len_limit < 24) ? len_limit : 24;
        if (pick < 10 || span == 0) begin
            len = 16'h0000;
        end else if (pick < 15 && (len_limit <= 64 || pick < 11) && len_limit <= 300) begin
            len = len_limit;
        end else begin
            len = 16'($urandom_range(1, span));
        end
        if (kind < 65) begin
            queue_frame(cmd, len, 16'h0000, eof_byte);
        end else if (kind < 75) begin
            if (len_limit == 16'hFFFF) begin
                queue_frame(cmd, len, 16'h0000, eof_byte);
            end else begin
                len = (pick < 50) ? len_limit + 16'd1
                                  : 16'($urandom_range(int'(len_limit) + 1, 65535));
                queue_frame(cmd, len, 16'h0000, eof_byte);
            end
        end else if (kind < 83) begin
            b = 8'($urandom_range(0, 255));
            if (b == eof_byte) begin
                b = ~b;
            end
            flip = (pick < 50) ? 16'h0000 : 16'($urandom_range(1, 65535));
            queue_frame(cmd, len, flip, b);
        end else if (kind < 91) begin
            queue_frame(cmd, len, 16'($urandom_range(1, 65535)), eof_byte);
        end else begin
            // Line noise; a stray start marker now and then breaks the next frame.
            repeat ($urandom_range(1, 6)) begin
                b = 8'($urandom_range(0, 255));
                if (b == sof_byte && !(len_limit <= 300 && $urandom_range(0, 7) == 0)) begin
                    b = ~b;
                end
                push_link_byte(b, 1'b0);
            end
        end
    endtask

    task automatic queue_random(input int target);
        int first;
        first = queued_items;
        while (queued_items - first < target) begin
            queue_random_frame();
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (link_bytes.size() != 0 || i_rx_valid || deframed_q.size() != 0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 23;
        receiver_idle_pct = 53;
        // Hunting noise, an empty good frame, the largest length, a bad end marker that
        // equals the start marker together with a bad CRC, and a plain CRC error.
        push_link_byte(8'h00, 1'b1);
        push_link_byte(8'hFF, 1'b1);
        queue_frame(8'hFF, 16'h0000, 16'h0000, eof_byte);
        queue_frame(8'h00, 16'hFFFF, 16'h0000, eof_byte);
        queue_frame(8'h3C, 16'h0000, 16'h0001, sof_byte);
        queue_frame(8'hC3, 16'h0001, 16'h8000, eof_byte);
        queue_random(260);
        wait_drained();

        write_reg(CFG_SPARE, 16'hFFFF);
        program_setting(8'h00, 8'hFF, 16'h0000);
        queue_random(290);
        wait_drained();

        sender_idle_pct   = 53;
        receiver_idle_pct = 23;
        program_setting(8'hFF, 8'h00, 16'hFFFF);
        queue_random(290);
        wait_drained();

        program_setting(8'h5A, 8'hA5, 16'd17);
        queue_random(290);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        program_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(1, 300)));
        queue_random(290);
        wait_drained();

        program_setting(START_MARKER_RST, END_MARKER_RST, MAX_LENGTH_RST);
        queue_random(290);
        wait_drained();

        repeat (5) @(posedge i_clk);
        if (deframed_q.size() != 0) begin
            mismatches += deframed_q.size();
            $display("%0d predicted results never arrived.", deframed_q.size());
        end
        $display("Sent %0d link bytes under %0d register settings, %0d payload bytes out.",
                 bytes_taken, settings_used, payload_bytes);
        $display("Frames: %0d good, %0d oversize, %0d CRC errors, %0d bad end markers.",
                 status_seen[ST_OK], status_seen[ST_OVERSIZE], status_seen[ST_CRC_BAD],
                 status_seen[ST_EOF_BAD]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
